// ===== src/command_mux_with_link_watchdog_core_macros.svh =====
// Assertion macros for the command mux with link watchdog.
// Used by the port checker; no other dependencies.
`ifndef COMMAND_MUX_WITH_LINK_WATCHDOG_CORE_MACROS_SVH
`define COMMAND_MUX_WITH_LINK_WATCHDOG_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CMWD_ASSERT_NOW(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cmwd check failed: condition does not hold");

// Check that a condition in one cycle implies another in the next.
`define CMWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmwd check failed: next-cycle condition does not hold");

`endif

// ===== src/cmwd_pkg.sv =====
// Package for the command mux with link watchdog: widths, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package cmwd_pkg;

  localparam int NCHAN      = 11;
  localparam int ABORT_CHAN = 10;
  localparam int CHAN_W     = 8;
  localparam int CNT_W      = 5;
  localparam int LIMIT_W    = 4;
  localparam int OP_W       = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [CNT_W-1:0]   COUNT_MAX         = 5'd31;
  localparam logic [LIMIT_W-1:0] STALE_LIMIT_RESET = 4'd3;
  localparam logic [0:0]         REG_STALE_LIMIT   = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_MANUAL = 2'd1,
    OP_AUTO   = 2'd2
  } op_t;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NCHAN-1:0] chan_vec_t;

  localparam chan_t ABORT_SET = 8'd1;

  localparam chan_vec_t RESET_CMDS = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                      8'd127, 8'd0, 8'd127, 8'd127};

  typedef struct packed {
    chan_vec_t        cmd;
    chan_vec_t        man_prev;
    chan_vec_t        man_latest;
    logic             man_fresh;
    logic             auto_fresh;
    logic [CNT_W-1:0] man_cnt;
    logic [CNT_W-1:0] auto_cnt;
  } wd_state_t;

  localparam wd_state_t WD_STATE_RESET = '{
    cmd:        RESET_CMDS,
    man_prev:   RESET_CMDS,
    man_latest: '0,
    man_fresh:  1'b0,
    auto_fresh: 1'b0,
    man_cnt:    '0,
    auto_cnt:   '0
  };

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + CNT_W'(1);
  endfunction

endpackage

// ===== src/cmwd_in_if.sv =====
// Input channel interface: valid/ready handshake with operation and channel values.
// Depends on cmwd_pkg.
`timescale 1ns / 1ps
interface cmwd_in_if;
  logic                   valid;
  logic                   ready;
  logic [cmwd_pkg::OP_W-1:0]   operation;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_0;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_1;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_2;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_3;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_4;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_5;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_6;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_7;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_8;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_9;
  logic [cmwd_pkg::CHAN_W-1:0] chan_in_10;

  modport source (
    output valid, operation, chan_in_0, chan_in_1, chan_in_2, chan_in_3, chan_in_4,
           chan_in_5, chan_in_6, chan_in_7, chan_in_8, chan_in_9, chan_in_10,
    input  ready
  );
  modport sink (
    input  valid, operation, chan_in_0, chan_in_1, chan_in_2, chan_in_3, chan_in_4,
           chan_in_5, chan_in_6, chan_in_7, chan_in_8, chan_in_9, chan_in_10,
    output ready
  );
endinterface

// ===== src/cmwd_out_if.sv =====
// Output channel interface: valid/ready handshake with the published command set.
// Depends on cmwd_pkg.
`timescale 1ns / 1ps
interface cmwd_out_if;
  logic                        valid;
  logic                        ready;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_0;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_1;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_2;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_3;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_4;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_5;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_6;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_7;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_8;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_9;
  logic [cmwd_pkg::CHAN_W-1:0] chan_out_10;

  modport source (
    output valid, chan_out_0, chan_out_1, chan_out_2, chan_out_3, chan_out_4,
           chan_out_5, chan_out_6, chan_out_7, chan_out_8, chan_out_9, chan_out_10,
    input  ready
  );
  modport sink (
    input  valid, chan_out_0, chan_out_1, chan_out_2, chan_out_3, chan_out_4,
           chan_out_5, chan_out_6, chan_out_7, chan_out_8, chan_out_9, chan_out_10,
    output ready
  );
endinterface

// ===== src/command_mux_with_link_watchdog_core.sv =====
// A tick is captured in the input register, then its result in the output register.
// Throughput: one transaction per cycle unless a tick stalls; the input register feeds
// the step logic, whose result goes to a single output register.
// A tick waits in the input register only while that output register is full and not taken.
// Reset: synchronous rst restores command set 127,127,0,127,0..., clears freshness
// and stale counters, and sets stale_limit to 3.
`timescale 1ns / 1ps
module command_mux_with_link_watchdog_core (
  input  logic                          clk,
  input  logic                          rst,
  cmwd_in_if.sink                       in_chan,
  cmwd_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmwd_pkg::PADDR_W-1:0]  paddr,
  input  logic [cmwd_pkg::PDATA_W-1:0]  pwdata,
  output logic [cmwd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import cmwd_pkg::*;

  logic [LIMIT_W-1:0] stale_limit;
  wd_state_t          state;
  wd_state_t          state_next;
  chan_vec_t          in_chans;
  logic               in_valid;
  logic [OP_W-1:0]    op;
  chan_vec_t          chans;
  logic               publish;
  chan_vec_t          result_next;
  logic               out_valid;
  chan_vec_t          result;
  logic               out_free;
  logic               fire;

  cmwd_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .stale_limit (stale_limit)
  );

  cmwd_step u_step (
    .state       (state),
    .op          (op),
    .chans       (chans),
    .stale_limit (stale_limit),
    .state_next  (state_next),
    .publish     (publish),
    .result      (result_next)
  );

  assign in_chans[0]  = in_chan.chan_in_0;
  assign in_chans[1]  = in_chan.chan_in_1;
  assign in_chans[2]  = in_chan.chan_in_2;
  assign in_chans[3]  = in_chan.chan_in_3;
  assign in_chans[4]  = in_chan.chan_in_4;
  assign in_chans[5]  = in_chan.chan_in_5;
  assign in_chans[6]  = in_chan.chan_in_6;
  assign in_chans[7]  = in_chan.chan_in_7;
  assign in_chans[8]  = in_chan.chan_in_8;
  assign in_chans[9]  = in_chan.chan_in_9;
  assign in_chans[10] = in_chan.chan_in_10;

  assign out_free      = !out_valid || out_chan.ready;
  assign fire          = in_valid && (!publish || out_free);
  assign in_chan.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      op    <= in_chan.operation;
      chans <= in_chans;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WD_STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && publish) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && publish) begin
      result <= result_next;
    end
  end

  assign out_chan.valid       = out_valid;
  assign out_chan.chan_out_0  = result[0];
  assign out_chan.chan_out_1  = result[1];
  assign out_chan.chan_out_2  = result[2];
  assign out_chan.chan_out_3  = result[3];
  assign out_chan.chan_out_4  = result[4];
  assign out_chan.chan_out_5  = result[5];
  assign out_chan.chan_out_6  = result[6];
  assign out_chan.chan_out_7  = result[7];
  assign out_chan.chan_out_8  = result[8];
  assign out_chan.chan_out_9  = result[9];
  assign out_chan.chan_out_10 = result[10];
endmodule

// ===== src/cmwd_cfg_regs.sv =====
// APB-style configuration register block holding the stale limit.
// Depends on cmwd_pkg.
`timescale 1ns / 1ps
module cmwd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cmwd_pkg::PADDR_W-1:0]   paddr,
  input  logic [cmwd_pkg::PDATA_W-1:0]   pwdata,
  output logic [cmwd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output logic [cmwd_pkg::LIMIT_W-1:0]   stale_limit
);
  import cmwd_pkg::*;

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1:2] == REG_STALE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      stale_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[LIMIT_W-1:0] = stale_limit;
    end
  end
endmodule

// ===== src/cmwd_step.sv =====
// Next-state and publish logic for one transaction of the command mux.
// Depends on cmwd_pkg.
`timescale 1ns / 1ps
module cmwd_step (
  input  cmwd_pkg::wd_state_t            state,
  input  logic [cmwd_pkg::OP_W-1:0]      op,
  input  cmwd_pkg::chan_vec_t            chans,
  input  logic [cmwd_pkg::LIMIT_W-1:0]   stale_limit,
  output cmwd_pkg::wd_state_t            state_next,
  output logic                           publish,
  output cmwd_pkg::chan_vec_t            result
);
  import cmwd_pkg::*;

  logic [CNT_W-1:0] auto_bump;
  logic [CNT_W-1:0] man_bump;
  logic [CNT_W-1:0] limit_ext;

  assign auto_bump = bump(state.auto_cnt);
  assign man_bump  = bump(state.man_cnt);
  assign limit_ext = {1'b0, stale_limit};

  always_comb begin
    state_next = state;
    publish    = 1'b0;
    case (op)
      OP_MANUAL: begin
        state_next.man_latest = chans;
        state_next.man_fresh  = 1'b1;
      end
      OP_AUTO: begin
        state_next.cmd        = chans;
        state_next.auto_fresh = 1'b1;
      end
      OP_TICK: begin
        publish = 1'b1;
        if (state.auto_fresh) begin
          state_next.auto_fresh = 1'b0;
          state_next.auto_cnt   = '0;
        end else begin
          state_next.auto_cnt = auto_bump;
          if (auto_bump > limit_ext) begin
            state_next.cmd[ABORT_CHAN] = ABORT_SET;
          end
        end
        if (state.man_fresh) begin
          for (int i = 0; i < NCHAN; i++) begin
            if (state.man_latest[i] != state.man_prev[i]) begin
              state_next.cmd[i]      = state.man_latest[i];
              state_next.man_prev[i] = state.man_latest[i];
            end
          end
          state_next.man_fresh = 1'b0;
          state_next.man_cnt   = '0;
        end else begin
          state_next.man_cnt = man_bump;
          if (man_bump > limit_ext) begin
            state_next.cmd[ABORT_CHAN] = ABORT_SET;
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
    result = state_next.cmd;
  end
endmodule

// ===== src/cmwd_checker.sv =====
// Port-level checker for the command mux with link watchdog, bound to the top level.
// Depends on cmwd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "command_mux_with_link_watchdog_core_macros.svh"
module cmwd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cmwd_pkg::CHAN_W-1:0] out_abort,
  input logic                        pready
);
  import cmwd_pkg::*;

  `CMWD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `CMWD_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_abort))
  `CMWD_ASSERT_NOW(a_ready_when_out_empty, clk, rst, out_valid || in_ready)
  `CMWD_ASSERT_NOW(a_ready_when_out_drains, clk, rst, !(out_valid && out_ready) || in_ready)
  `CMWD_ASSERT_NOW(a_pready_high, clk, rst, pready)
endmodule

bind command_mux_with_link_watchdog_core cmwd_checker u_cmwd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_abort (out_chan.chan_out_10),
  .pready    (pready)
);
